/* hw/rtl/swsp_pkg.sv */
`default_nettype none
package swsp_pkg;

	localparam int WINDOW_DEPTH = 5;

	localparam int SAMPLE_W  = 16;
	localparam int INDEX_W   = 16;
	localparam int THR_W     = 24;
	localparam int RUN_W     = 8;
	localparam int CFG_IDX_W = 2;

	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int POS_W  = $clog2(WINDOW_DEPTH);
	localparam int WMAX   = WINDOW_DEPTH * (WINDOW_DEPTH - 1) / 2;
	localparam int W_W    = $clog2(WMAX + 1) + 1;
	localparam int PROD_W = SAMPLE_W + W_W;
	localparam int NUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH * WMAX + 1) + 1;
	localparam int DMAX   = WINDOW_DEPTH * WINDOW_DEPTH * (WINDOW_DEPTH * WINDOW_DEPTH - 1) / 12;
	localparam int DEN_W  = $clog2(DMAX + 1);
	localparam int THRP_W = THR_W + DEN_W + 1;
	localparam int LHS_W  = NUM_W + 8;
	localparam int CMP_W  = ((LHS_W > THRP_W) ? LHS_W : THRP_W) + 1;
	localparam int GRP_N  = (WINDOW_DEPTH + 3) / 4;

	localparam logic [INDEX_W-1:0] NO_PEAK = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE = 2'd0,
		REG_FALL = 2'd1,
		REG_RUN  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0]   n;
		logic [INDEX_W-1:0] idx;
		logic               last;
	} tag_t;

	typedef logic [DEN_W-1:0] den_tab_t [WINDOW_DEPTH+1];

	// n*Sxx - Sx*Sx for x = 0..n-1
	function automatic den_tab_t build_den();
		den_tab_t t;
		for (int n = 0; n <= WINDOW_DEPTH; n++) begin
			t[n] = DEN_W'(n * n * (n * n - 1) / 12);
		end
		return t;
	endfunction

	localparam den_tab_t DEN_TAB = build_den();

	// weight of the sample of age j (0 = newest) in n*Sxy - Sx*Sy
	function automatic logic signed [W_W-1:0] slope_weight(logic [CNT_W-1:0] n,
			logic [POS_W-1:0] j);
		int ni;
		int ji;
		int w;
		ni = int'(n);
		ji = int'(j);
		w  = 0;
		if (ji < ni) begin
			w = ni * (ni - 1 - ji) - ((ni * (ni - 1)) >>> 1);
		end
		return W_W'(w);
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/swsp_cell.sv */
`default_nettype none
module swsp_cell import swsp_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       adv,
	input  wire logic                       shift_en,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic [POS_W-1:0]           pos,
	input  wire logic [CNT_W-1:0]           n_s1,
	output logic signed [SAMPLE_W-1:0]      sample_out,
	output logic signed [PROD_W-1:0]        prod_s2
);

	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [W_W-1:0]      weight;

	assign weight     = slope_weight(n_s1, pos);
	assign sample_out = sample_s1;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_s1 <= sample_in;
		end
		if (adv) begin
			prod_s2 <= (pos < n_s1) ? PROD_W'(sample_s1) * PROD_W'(weight) : PROD_W'(0);
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/swsp_ctrl.sv */
`default_nettype none
module swsp_ctrl import swsp_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     v_s4,
	input  wire tag_t                     tag_s4,
	input  wire logic signed [NUM_W-1:0]  num_s4,
	input  wire logic signed [THRP_W-1:0] rp_s4,
	input  wire logic signed [THRP_W-1:0] fp_s4,
	input  wire logic [RUN_W-1:0]         run_len,
	output logic                          out_valid,
	output logic                          peak_found,
	output logic [INDEX_W-1:0]            peak_loc
);

	logic               rising_q, rising_d;
	logic               rep_q, rep_d;
	logic [RUN_W-1:0]   run_q, run_d;
	logic [INDEX_W-1:0] cand_q, cand_d;
	logic               out_valid_q;
	logic               found_q;
	logic [INDEX_W-1:0] index_q;

	logic signed [CMP_W-1:0] lhs, rhs_rise, rhs_fall;
	logic                    gt_rise, lt_fall;
	logic                    emit, found;
	logic [INDEX_W-1:0]      idx_o;
	logic                    step;

	assign lhs      = {{(CMP_W - LHS_W){num_s4[NUM_W-1]}}, num_s4, 8'b0};
	assign rhs_rise = {{(CMP_W - THRP_W){rp_s4[THRP_W-1]}}, rp_s4};
	assign rhs_fall = {{(CMP_W - THRP_W){fp_s4[THRP_W-1]}}, fp_s4};
	assign gt_rise  = lhs > rhs_rise;
	assign lt_fall  = lhs < rhs_fall;
	assign step     = adv && v_s4;

	always_comb begin
		rising_d = rising_q;
		run_d    = run_q;
		cand_d   = cand_q;
		rep_d    = rep_q;
		emit     = 1'b0;
		found    = 1'b0;
		idx_o    = NO_PEAK;
		if (!rep_q) begin
			if (tag_s4.n >= CNT_W'(2)) begin
				if (gt_rise) begin
					rising_d = 1'b1;
					cand_d   = tag_s4.idx;
					run_d    = '0;
				end else if (rising_q) begin
					if (lt_fall) begin
						if (run_q != '1) begin
							run_d = run_q + 1'b1;
						end
					end else begin
						run_d = '0;
					end
					if (run_d >= run_len) begin
						emit  = 1'b1;
						found = 1'b1;
						idx_o = cand_q;
						rep_d = 1'b1;
					end
				end
			end
			if (tag_s4.last && !emit) begin
				emit  = 1'b1;
				found = 1'b0;
				idx_o = NO_PEAK;
			end
		end
		if (tag_s4.last) begin
			rising_d = 1'b0;
			run_d    = '0;
			cand_d   = NO_PEAK;
			rep_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rising_q    <= 1'b0;
			rep_q       <= 1'b0;
			run_q       <= '0;
			cand_q      <= NO_PEAK;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				rising_q <= rising_d;
				rep_q    <= rep_d;
				run_q    <= run_d;
				cand_q   <= cand_d;
			end
			if (adv) begin
				out_valid_q <= v_s4 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			found_q <= found;
			index_q <= idx_o;
		end
	end

	assign out_valid  = out_valid_q;
	assign peak_found = found_q;
	assign peak_loc   = index_q;

	a_nopeak_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> index_q == NO_PEAK)
		else $error("no-peak item with an index");

	a_report_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && found && !tag_s4.last |=> rep_q)
		else $error("peak reported but not recorded");

	a_quiet_after_peak: assert property (@(posedge clk) disable iff (!arst_n)
		step && rep_q |=> !out_valid_q)
		else $error("item emitted after a reported peak");

	a_rep_needs_rise: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> rising_q)
		else $error("peak reported without a rising trend");

endmodule
`default_nettype wire

/* hw/rtl/sliding_window_slope_peak_detector_top.sv */
// Each accepted sample passes stages s1 to s4 and then the output register.
// Throughput: one sample per cycle; a stalled result holds the whole pipeline.
// The slope is formed by a row of window cells (one multiply each) and a
// registered two-level adder tree; the decision stage updates once per item.
// Reset clears the trend state and out_valid, thresholds return to defaults.
`default_nettype none
module sliding_window_slope_peak_detector_top import swsp_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [INDEX_W-1:0]         sample_index,
	input  wire logic                       last_in_interval,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            peak_found,
	output logic [INDEX_W-1:0]              peak_loc,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [THR_W-1:0]           cfg_data
);

	logic adv, accept;

	logic signed [THR_W-1:0] rise_q, fall_q;
	logic [RUN_W-1:0]        run_len_q;

	logic [CNT_W-1:0] fill_q, n_new;

	logic v_s1, v_s2, v_s3, v_s4;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [SAMPLE_W-1:0] chain [WINDOW_DEPTH];
	logic signed [PROD_W-1:0]   prod_s2 [WINDOW_DEPTH];

	logic signed [THRP_W-1:0] rp_s2, fp_s2, rp_s3, fp_s3, rp_s4, fp_s4;
	logic signed [NUM_W-1:0]  grp_d [GRP_N];
	logic signed [NUM_W-1:0]  grp_s3 [GRP_N];
	logic signed [NUM_W-1:0]  num_d, num_s4;
	logic signed [DEN_W:0]    den_s1;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign accept    = in_valid && adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q    <= THR_W'(256);
			fall_q    <= THR_W'(-256);
			run_len_q <= RUN_W'(5);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_RISE: rise_q    <= cfg_data;
				REG_FALL: fall_q    <= cfg_data;
				REG_RUN:  run_len_q <= cfg_data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_new = (fill_q == CNT_W'(WINDOW_DEPTH)) ? fill_q : fill_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else if (adv) begin
			if (accept) begin
				fill_q <= last_in_interval ? '0 : n_new;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1.n    <= n_new;
			tag_s1.idx  <= sample_index;
			tag_s1.last <= last_in_interval;
		end
		if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_cell
		logic signed [SAMPLE_W-1:0] cell_in;
		if (j == 0) begin : g_head
			assign cell_in = sample;
		end else begin : g_link
			assign cell_in = chain[j-1];
		end
		swsp_cell u_cell (
			.clk        (clk),
			.adv        (adv),
			.shift_en   (accept),
			.sample_in  (cell_in),
			.pos        (POS_W'(j)),
			.n_s1       (tag_s1.n),
			.sample_out (chain[j]),
			.prod_s2    (prod_s2[j])
		);
	end

	assign den_s1 = {1'b0, DEN_TAB[tag_s1.n]};

	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_d[g] = '0;
		end
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			grp_d[i >> 2] = grp_d[i >> 2] + NUM_W'(prod_s2[i]);
		end
	end

	always_comb begin
		num_d = '0;
		for (int g = 0; g < GRP_N; g++) begin
			num_d = num_d + grp_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_s2  <= THRP_W'(rise_q) * THRP_W'(den_s1);
			fp_s2  <= THRP_W'(fall_q) * THRP_W'(den_s1);
			rp_s3  <= rp_s2;
			fp_s3  <= fp_s2;
			rp_s4  <= rp_s3;
			fp_s4  <= fp_s3;
			grp_s3 <= grp_d;
			num_s4 <= num_d;
		end
	end

	swsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.v_s4       (v_s4),
		.tag_s4     (tag_s4),
		.num_s4     (num_s4),
		.rp_s4      (rp_s4),
		.fp_s4      (fp_s4),
		.run_len    (run_len_q),
		.out_valid  (out_valid),
		.peak_found (peak_found),
		.peak_loc   (peak_loc)
	);

endmodule
`default_nettype wire

/* verif/sliding_window_slope_peak_detector_top_tb.sv */
`timescale 1ns / 100ps
module sliding_window_slope_peak_detector_top_tb;
	import swsp_pkg::*;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic [INDEX_W-1:0]         sample_index = '0;
	logic                       last_in_interval = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       peak_found;
	logic [INDEX_W-1:0]         peak_loc;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [THR_W-1:0]           cfg_data = '0;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] idx;
	} peak_result_t;

	class slope_peak_checker;
		logic signed [THR_W-1:0]    rise_thr;
		logic signed [THR_W-1:0]    fall_thr;
		logic [RUN_W-1:0]           run_len;
		logic signed [SAMPLE_W-1:0] win [WINDOW_DEPTH];
		int                         fill;
		bit                         rising;
		int                         fall_run;
		logic [INDEX_W-1:0]         cand;
		bit                         reported;
		peak_result_t               expected_peaks [$];
		int                         mismatches;
		int                         accepted;

		function new();
			rise_thr   = THR_W'(256);
			fall_thr   = THR_W'(-256);
			run_len    = RUN_W'(5);
			mismatches = 0;
			accepted   = 0;
			clear();
		endfunction

		function void clear();
			fill     = 0;
			rising   = 0;
			fall_run = 0;
			cand     = NO_PEAK;
			reported = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [THR_W-1:0] d);
			case (r)
				REG_RISE: rise_thr = d;
				REG_FALL: fall_thr = d;
				REG_RUN:  run_len = d[RUN_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_peaks.size();
		endfunction

		// sign of slope - thr/256, without division
		function int cmp_slope(longint num, longint den, logic signed [THR_W-1:0] thr);
			longint l;
			longint r;
			l = num * 256;
			r = longint'(thr) * den;
			return (l > r) ? 1 : ((l < r) ? -1 : 0);
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] y, logic [INDEX_W-1:0] idx,
				logic is_last);
			longint       n, sx, sy, sxx, sxy, num, den, xi;
			bit           emitted;
			peak_result_t res;
			emitted = 0;
			if (!reported) begin
				accepted++;
				if (fill < WINDOW_DEPTH) begin
					win[fill] = y;
					fill++;
				end else begin
					for (int i = 0; i < WINDOW_DEPTH - 1; i++)
						win[i] = win[i+1];
					win[WINDOW_DEPTH-1] = y;
				end
				if (fill >= 2) begin
					n   = longint'(fill);
					sx  = 0;
					sy  = 0;
					sxx = 0;
					sxy = 0;
					for (int i = 0; i < fill; i++) begin
						xi = longint'(i);
						sx  += xi;
						sy  += longint'(win[i]);
						sxx += xi * xi;
						sxy += xi * longint'(win[i]);
					end
					num = n * sxy - sx * sy;
					den = n * sxx - sx * sx;
					if (cmp_slope(num, den, rise_thr) > 0) begin
						rising   = 1;
						cand     = idx;
						fall_run = 0;
					end else if (rising) begin
						if (cmp_slope(num, den, fall_thr) < 0) begin
							if (fall_run < 255)
								fall_run++;
						end else begin
							fall_run = 0;
						end
						if (fall_run >= run_len) begin
							res.found = 1'b1;
							res.idx   = cand;
							expected_peaks.push_back(res);
							emitted  = 1;
							reported = 1;
						end
					end
				end
				if (is_last && !emitted) begin
					res.found = 1'b0;
					res.idx   = NO_PEAK;
					expected_peaks.push_back(res);
				end
			end
			if (is_last)
				clear();
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_peak(logic found, logic [INDEX_W-1:0] idx);
			peak_result_t e;
			if (expected_peaks.size() == 0) begin
				report($sformatf("unexpected result found=%0b index=%0d", found, idx));
			end else begin
				e = expected_peaks.pop_front();
				if (found !== e.found)
					report($sformatf("peak_found %0b, want %0b", found, e.found));
				if (idx !== e.idx)
					report($sformatf("peak_loc %0d, want %0d", idx, e.idx));
			end
		endtask
	endclass

	slope_peak_checker sb;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int cyc = 0;

	sliding_window_slope_peak_detector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.sample_index(sample_index),
		.last_in_interval(last_in_interval),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.peak_found(peak_found),
		.peak_loc(peak_loc),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		cyc++;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= cyc[2];
		endcase
	end

	// results are checked before the same edge's item is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_peak(peak_found, peak_loc);
			if (in_valid && !in_stall)
				sb.take_sample(sample, sample_index, last_in_interval);
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] clip(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return SAMPLE_W'(v);
	endfunction

	function automatic int jitter(int a);
		return int'($urandom_range(0, 2 * a)) - a;
	endfunction

	task automatic push_sample(logic signed [SAMPLE_W-1:0] y, logic [INDEX_W-1:0] idx,
			logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid         <= 1'b1;
		sample           <= y;
		sample_index     <= idx;
		last_in_interval <= is_last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_values(int vals[$], logic [INDEX_W-1:0] idx0);
		logic [INDEX_W-1:0] idx;
		idx = idx0;
		for (int k = 0; k < vals.size(); k++) begin
			push_sample(clip(vals[k]), idx, k == vals.size() - 1);
			idx = ($urandom_range(0, 15) == 0) ? INDEX_W'($urandom) : idx + 1'b1;
		end
	endtask

	// wait for every expected peak, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic [THR_W-1:0] rise, logic [THR_W-1:0] fall,
			logic [RUN_W-1:0] run);
		cfg_reg_t         regs [3];
		logic [THR_W-1:0] vals [3];
		regs = '{REG_RISE, REG_FALL, REG_RUN};
		vals = '{rise, fall, {(THR_W-RUN_W)'($urandom), run}};
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(regs[k], vals[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	// 0: rise then fall, 1: full-range noise, 2: flat, 3: long fall
	task automatic send_interval(int kind);
		int vals [$];
		int lvl, up, dn, amp, n1, n2;
		case (kind)
			0: begin
				lvl = int'($urandom_range(0, 50000)) - 25000;
				up  = $urandom_range(0, 2500);
				dn  = $urandom_range(0, 2500);
				case ($urandom_range(0, 2))
					0: amp = 0;
					1: amp = 60;
					default: amp = 900;
				endcase
				n1 = $urandom_range(1, 6);
				n2 = $urandom_range(0, 10);
				for (int k = 0; k < n1; k++) begin
					lvl += up;
					vals.push_back(lvl + jitter(amp));
				end
				for (int k = 0; k < n2; k++) begin
					lvl -= dn;
					vals.push_back(lvl + jitter(amp));
				end
				repeat ($urandom_range(0, 3)) vals.push_back(lvl + jitter(2000));
			end
			1: begin
				repeat ($urandom_range(1, 10))
					vals.push_back(int'($urandom_range(0, 65535)) - 32768);
			end
			2: begin
				case ($urandom_range(0, 2))
					0: lvl = -32768;
					1: lvl = 32767;
					default: lvl = int'($urandom_range(0, 65535)) - 32768;
				endcase
				repeat ($urandom_range(1, 8)) vals.push_back(lvl);
			end
			default: begin
				lvl = -20000;
				repeat (8) begin
					lvl += 400;
					vals.push_back(lvl);
				end
				repeat (262) begin
					lvl -= 3;
					vals.push_back(lvl);
				end
			end
		endcase
		send_values(vals, INDEX_W'($urandom));
	endtask

	initial begin
		int               seq [$];
		int               start;
		int               pick;
		logic [THR_W-1:0] rise, fall;
		logic [RUN_W-1:0] run;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// peak declared on the last item, index 65535 as the peak unless a random index jump intervenes
		seq = '{0, 1000, 2000, -5000, -10000, -15000, -20000, -25000};
		send_values(seq, 16'd65533);
		// peak, then ignored items, then a silent last item
		seq = '{0, 1000, 2000, -5000, -10000, -15000, -20000, -25000, 32767, -32768};
		send_values(seq, 16'd10);
		// single-item interval, then a flat one at full scale
		seq = '{-32768};
		send_values(seq, 16'd0);
		seq = '{32767, 32767, 32767};
		send_values(seq, 16'd500);
		drain();

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: begin rise = 24'd256;     fall = -24'sd256;   run = 8'd5;   end
				1: begin rise = 24'd128;     fall = -24'sd128;   run = 8'd1;   end
				2: begin rise = 24'h7fffff;  fall = 24'h800000;  run = 8'd255; end
				3: begin rise = 24'h800000;  fall = 24'h7fffff;  run = 8'd1;   end
				4: begin rise = 24'd0;       fall = 24'd0;       run = 8'd0;   end
				5: begin rise = 24'd256;     fall = -24'sd256;   run = 8'd255; end
				default: begin
					rise = THR_W'(int'($urandom_range(0, 400000)) - 30000);
					fall = THR_W'(30000 - int'($urandom_range(0, 400000)));
					run  = RUN_W'($urandom_range(1, 8));
				end
			endcase
			set_config(rise, fall, run);
			if (p == 5)
				send_interval(3);
			start = sb.accepted;
			while (sb.accepted - start < 55) begin
				pick = $urandom_range(0, 9);
				send_interval(pick == 7 ? 1 : (pick == 8 ? 2 : 0));
			end
			drain();
		end

		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/swsp_pkg.sv
hw/rtl/swsp_cell.sv
hw/rtl/swsp_ctrl.sv
hw/rtl/sliding_window_slope_peak_detector_top.sv
verif/sliding_window_slope_peak_detector_top_tb.sv
